[rtl/core/aecd_pkg.sv]
`timescale 1ns / 1ps
// aecd_pkg: widths, codes and beat types shared by the alpha-edge color dilation core.
// No dependencies; compiled before every other file of the core.
package aecd_pkg;

    localparam int W_W        = 11;   // image width field
    localparam int H_W        = 13;   // image height field
    localparam int TOTAL_W    = 23;   // width * height, at most 2047 * 4096
    localparam int SPAN_W     = 16;   // passes * width, at most 32 * 2047
    localparam int T_W        = 24;   // item position inside a frame
    localparam int Q_W        = T_W + 1;  // signed pixel index of a pass
    localparam int PIX_W      = 32;
    localparam int ALPHA_W    = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    localparam logic              CMD_FLUSH    = 1'b1;
    localparam logic [W_W-1:0]    WIDTH_RESET  = 11'd1024;
    localparam logic [H_W-1:0]    HEIGHT_RESET = 13'd1;
    localparam logic [H_W-1:0]    HEIGHT_CAP   = 13'd4096;
    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // One ring entry: pixel of a pass plus the alpha the pixel came in with
    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [PIX_W-1:0]   pixel;
    } entry_t;

    // One slot moving down the cell chain
    typedef struct packed {
        logic                  valid;
        logic signed [Q_W-1:0] q;        // index of the pixel carried in data
        logic [W_W-1:0]        col;      // column, same for every pass
        logic                  fresh_ok; // data holds a pixel of the frame
        entry_t                data;
    } slot_t;

    // Frame geometry derived from the registers
    typedef struct packed {
        logic [W_W-1:0]     width;
        logic [W_W-1:0]     width_m1;
        logic               width_one;
        logic [TOTAL_W-1:0] total;
    } cfg_t;

endpackage

[rtl/core/aecd_front.sv]
`timescale 1ns / 1ps
// aecd_front: configuration registers, frame geometry and item position counters.
// Turns accepted input beats into slots for the cell chain. Uses aecd_pkg.
module aecd_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int PASSES    = 11
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [0:0]                      s_tuser,
    input  logic [aecd_pkg::PIX_W-1:0]      s_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aecd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aecd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output aecd_pkg::cfg_t                  cfg,
    output aecd_pkg::slot_t                 slot_out
);
    localparam int WW = aecd_pkg::W_W;
    localparam int HW = aecd_pkg::H_W;
    localparam int TW = aecd_pkg::TOTAL_W;
    localparam int SW = aecd_pkg::SPAN_W;
    localparam int PW = aecd_pkg::T_W;
    localparam logic [WW-1:0] W_CAP =
        WW'((MAX_WIDTH > (2**WW - 1)) ? (2**WW - 1) : MAX_WIDTH);

    logic [WW-1:0] image_width_reg;
    logic [HW-1:0] image_height_reg;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [TW-1:0] total_next;
    logic [SW-1:0] span_next;

    logic [WW-1:0] w_reg, w_m1_reg;
    logic          w_one_reg;
    logic [TW-1:0] total_reg;
    logic [SW-1:0] span_reg;
    logic [PW-1:0] end_reg;
    logic [1:0]    busy_reg;

    logic [PW-1:0] t_reg, t_next, t0;
    logic [WW-1:0] col_reg, col_next, col0;
    logic          wrap, fresh_ok, ignore, take, cfg_hit;
    aecd_pkg::slot_t slot_next, slot_reg;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && cfg_ready &&
                       (cfg_index == aecd_pkg::REG_IMAGE_WIDTH ||
                        cfg_index == aecd_pkg::REG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= aecd_pkg::WIDTH_RESET;
            image_height_reg <= aecd_pkg::HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == aecd_pkg::REG_IMAGE_WIDTH) begin
                image_width_reg <= cfg_wdata[WW-1:0];
            end else if (cfg_index == aecd_pkg::REG_IMAGE_HEIGHT) begin
                image_height_reg <= cfg_wdata[HW-1:0];
            end
        end
    end

    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (image_width_reg > W_CAP) begin
            w_eff = W_CAP;
        end else begin
            w_eff = image_width_reg;
        end
        if (image_height_reg == '0) begin
            h_eff = HW'(1);
        end else if (image_height_reg > aecd_pkg::HEIGHT_CAP) begin
            h_eff = aecd_pkg::HEIGHT_CAP;
        end else begin
            h_eff = image_height_reg;
        end
    end

    assign total_next = {{(TW-WW){1'b0}}, w_eff} * {{(TW-HW){1'b0}}, h_eff};
    assign span_next  = SW'(PASSES) * {{(SW-WW){1'b0}}, w_eff};

    // Geometry is registered, end_reg after total_reg; the busy count covers that
    always_ff @(posedge aclk) begin
        w_reg     <= w_eff;
        w_m1_reg  <= w_eff - WW'(1);
        w_one_reg <= (w_eff == WW'(1));
        total_reg <= total_next;
        span_reg  <= span_next;
        end_reg   <= {{(PW-TW){1'b0}}, total_reg} + {{(PW-SW){1'b0}}, span_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 2'd3;
        end else if (cfg_hit) begin
            busy_reg <= 2'd2;
        end else if (busy_reg != 2'd0) begin
            busy_reg <= busy_reg - 2'd1;
        end
    end

    assign s_tready = ce && (busy_reg == 2'd0);

    assign wrap     = (t_reg >= end_reg);
    assign t0       = wrap ? '0 : t_reg;
    assign col0     = wrap ? '0 : col_reg;
    assign fresh_ok = (t0 < {{(PW-TW){1'b0}}, total_reg});
    // a flush beat while pixels are still due is dropped
    assign ignore   = (s_tuser[0] == aecd_pkg::CMD_FLUSH) && fresh_ok;
    assign take     = s_tvalid && s_tready && !ignore;
    assign t_next   = t0 + PW'(1);
    assign col_next = (col0 == w_m1_reg) ? '0 : col0 + WW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_reg   <= '0;
            col_reg <= '0;
        end else if (cfg_hit) begin
            t_reg   <= '0;
            col_reg <= '0;
        end else if (take) begin
            t_reg   <= t_next;
            col_reg <= col_next;
        end
    end

    always_comb begin
        slot_next.valid      = take;
        slot_next.q          = $signed({1'b0, t0});
        slot_next.col        = col0;
        slot_next.fresh_ok   = fresh_ok;
        slot_next.data.alpha = s_tdata[31:24];
        slot_next.data.pixel = fresh_ok ? s_tdata : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else if (ce) begin
            slot_reg <= slot_next;
        end
    end

    assign slot_out      = slot_reg;
    assign cfg.width     = w_reg;
    assign cfg.width_m1  = w_m1_reg;
    assign cfg.width_one = w_one_reg;
    assign cfg.total     = total_reg;

endmodule

[rtl/core/aecd_cell.sv]
`timescale 1ns / 1ps
// aecd_cell: one dilation pass. Keeps a two-row ring of the previous pass in a memory
// and a three-pixel window in registers. Uses aecd_pkg.
module aecd_cell #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  aecd_pkg::cfg_t  cfg,
    input  aecd_pkg::slot_t slot_in,
    output aecd_pkg::slot_t slot_out
);
    localparam int QW         = aecd_pkg::Q_W;
    localparam int WW         = aecd_pkg::W_W;
    localparam int TW         = aecd_pkg::TOTAL_W;
    localparam int RING_AW    = $clog2(2 * MAX_WIDTH);
    localparam int RING_DEPTH = 2**RING_AW;
    localparam logic signed [QW-1:0] ONE_S = 1;

    logic signed [QW-1:0] w_s, total_s, m, m_up, m_right;
    logic [RING_AW-1:0]   addr_wr, addr_up, addr_right;

    aecd_pkg::entry_t ring_mem [RING_DEPTH];
    aecd_pkg::entry_t rd_right_reg, rd_up_reg;

    logic                 b_valid_reg;
    logic signed [QW-1:0] b_m_reg;
    logic [WW-1:0]        b_col_reg;
    logic                 b_v_ok_reg, b_up_ok_reg, b_down_ok_reg;
    aecd_pkg::entry_t     b_below_reg;
    aecd_pkg::entry_t     win_self_reg, win_left_reg;

    logic                 left_ok, right_ok;
    logic [aecd_pkg::PIX_W-1:0] result;
    aecd_pkg::slot_t      slot_next, slot_reg;

    assign w_s     = $signed({{(QW-WW){1'b0}}, cfg.width});
    assign total_s = $signed({{(QW-TW){1'b0}}, cfg.total});

    // incoming slot carries pixel q of the previous pass; this pass decides m = q - w
    assign m       = slot_in.q - w_s;
    assign m_up    = m - w_s;
    assign m_right = m + ONE_S;

    assign addr_wr    = slot_in.q[RING_AW-1:0];
    assign addr_up    = m_up[RING_AW-1:0];
    assign addr_right = m_right[RING_AW-1:0];

    // read-first: a slot sees the ring as it stood before its own write
    always_ff @(posedge aclk) begin
        if (ce) begin
            rd_right_reg <= ring_mem[addr_right];
            rd_up_reg    <= ring_mem[addr_up];
            if (slot_in.valid && slot_in.fresh_ok) begin
                ring_mem[addr_wr] <= slot_in.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ce) begin
            b_valid_reg <= slot_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_m_reg       <= m;
            b_col_reg     <= slot_in.col;
            b_v_ok_reg    <= !m[QW-1] && (m < total_s);
            b_up_ok_reg   <= !m_up[QW-1];
            b_down_ok_reg <= (slot_in.q < total_s);
            b_below_reg   <= slot_in.data;
        end
    end

    assign left_ok  = (b_col_reg != '0);
    assign right_ok = (b_col_reg != cfg.width_m1);

    always_comb begin
        result = win_self_reg.pixel;
        if (win_self_reg.pixel[31:24] == '0) begin
            if (b_up_ok_reg && rd_up_reg.pixel[31:24] != '0) begin
                result = {aecd_pkg::ALPHA_OPAQUE, rd_up_reg.pixel[23:0]};
            end else if (left_ok && win_left_reg.pixel[31:24] != '0) begin
                result = {aecd_pkg::ALPHA_OPAQUE, win_left_reg.pixel[23:0]};
            end else if (right_ok && rd_right_reg.pixel[31:24] != '0) begin
                result = {aecd_pkg::ALPHA_OPAQUE, rd_right_reg.pixel[23:0]};
            end else if (b_down_ok_reg && b_below_reg.pixel[31:24] != '0) begin
                result = {aecd_pkg::ALPHA_OPAQUE, b_below_reg.pixel[23:0]};
            end
        end
    end

    // Window slides one pixel per slot. At width one the next self is the pixel
    // written by this slot, which the ring read cannot see yet.
    always_ff @(posedge aclk) begin
        if (ce && b_valid_reg) begin
            win_left_reg <= win_self_reg;
            win_self_reg <= cfg.width_one ? b_below_reg : rd_right_reg;
        end
    end

    always_comb begin
        slot_next.valid      = b_valid_reg;
        slot_next.q          = b_m_reg;
        slot_next.col        = b_col_reg;
        slot_next.fresh_ok   = b_v_ok_reg;
        slot_next.data.alpha = win_self_reg.alpha;
        slot_next.data.pixel = result;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else if (ce) begin
            slot_reg <= slot_next;
        end
    end

    assign slot_out = slot_reg;

endmodule

[rtl/core/alpha_edge_color_dilation.sv]
`timescale 1ns / 1ps
// The result for pixel m is released by input beat m + PASSES*width (flush beats drain the
//   frame). Throughput: one beat per cycle unless the busy count or a held skid beat stalls
//   the input; each pass cell does one ring write and two reads a cycle.
// Reset: synchronous, active low; width 1024, height 1, positions zero. s_tready stays low
//   after reset and a register write until busy_reg is zero. Ring memories are not cleared.
module alpha_edge_color_dilation #(
    parameter int MAX_WIDTH = 1024,
    parameter int PASSES    = 11
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [aecd_pkg::PIX_W-1:0]      s_tdata,   // [31:0] in_pixel
    input  logic [0:0]                      s_tuser,   // [0] cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [aecd_pkg::PIX_W-1:0]      m_tdata,   // [31:0] out_pixel
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aecd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aecd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    localparam int QW = aecd_pkg::Q_W;
    localparam int TW = aecd_pkg::TOTAL_W;
    localparam int PW = aecd_pkg::PIX_W;
    localparam logic signed [QW-1:0] ONE_S = 1;

    logic            ce;
    aecd_pkg::cfg_t  cfg;
    aecd_pkg::slot_t chain [PASSES+1];
    aecd_pkg::slot_t fin;

    logic                 res_valid, res_last, take;
    logic [PW-1:0]        res_data;
    logic signed [QW-1:0] last_q;

    logic          out_valid_reg, out_last_reg, skid_valid_reg, skid_last_reg;
    logic [PW-1:0] out_data_reg, skid_data_reg;

    // whole chain freezes only while the skid beat is occupied
    assign ce = !skid_valid_reg;

    aecd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .PASSES    (PASSES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .slot_out  (chain[0])
    );

    for (genvar i = 0; i < PASSES; i++) begin : g_pass
        aecd_cell #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ce       (ce),
            .cfg      (cfg),
            .slot_in  (chain[i]),
            .slot_out (chain[i+1])
        );
    end

    assign fin       = chain[PASSES];
    assign last_q    = $signed({{(QW-TW){1'b0}}, cfg.total}) - ONE_S;
    assign res_valid = fin.valid && fin.fresh_ok;
    assign res_last  = (fin.q == last_q);
    assign res_data  = {fin.data.alpha, fin.data.pixel[23:0]};
    assign take      = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                out_data_reg   <= skid_data_reg;
                out_last_reg   <= skid_last_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || take) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res_data;
                out_last_reg  <= res_last;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res_data;
                skid_last_reg  <= res_last;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

[rtl/core/aecd_checker.sv]
`timescale 1ns / 1ps
// aecd_checker: port-level assertions for alpha_edge_color_dilation, bound to the top.
// Uses aecd_pkg for register indexes.
module aecd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [aecd_pkg::PIX_W-1:0]     m_tdata,
    input logic                           m_tlast,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [aecd_pkg::CFG_IDX_W-1:0] cfg_index
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // geometry is being recomputed right after a register write
    a_cfg_block: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready &&
        (cfg_index == aecd_pkg::REG_IMAGE_WIDTH || cfg_index == aecd_pkg::REG_IMAGE_HEIGHT)
        |=> !s_tready)
        else $error("input accepted before geometry settled");

    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_tready && !m_tvalid)
        else $error("channel active right after reset");

endmodule

bind alpha_edge_color_dilation aecd_checker u_aecd_checker (.*);
